[src/rounded_greedy_change_maker_top_macros.svh]
// Assertion macros shared by the rounded greedy change maker RTL.
`ifndef ROUNDED_GREEDY_CHANGE_MAKER_TOP_MACROS_SVH
`define ROUNDED_GREEDY_CHANGE_MAKER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property at every rising clock edge outside reset.
`define RGCM_ASSERT(name, clock, reset, prop) \
  name: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("rgcm assertion failed");

// Checks that a condition in one cycle implies a consequence in the next.
`define RGCM_ASSERT_NEXT(name, clock, reset, cond, conseq) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
    else $error("rgcm assertion failed");

`else

`define RGCM_ASSERT(name, clock, reset, prop)

`define RGCM_ASSERT_NEXT(name, clock, reset, cond, conseq)

`endif

`endif

[src/rgcm_pkg.sv]
// Types, constants and microcode table of the rounded greedy change maker.
package rgcm_pkg;

  localparam int FIELD_BITS  = 16;
  localparam int KIND_W      = 2;
  localparam int IDX_W       = 4;
  localparam int COUNT_W     = 6;
  localparam int DENOM_W     = 11;
  localparam int DENOM_COUNT = 9;
  localparam int STEP_W      = 3;

  localparam logic [KIND_W-1:0] KIND_NOT_ENOUGH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXACT      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHANGE     = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE        = 3'd0;
  localparam step_t STEP_ROUND_COST  = 3'd1;
  localparam step_t STEP_ROUND_PAID  = 3'd2;
  localparam step_t STEP_SETUP       = 3'd3;
  localparam step_t STEP_SUBTRACT    = 3'd4;
  localparam step_t STEP_EMIT_CHANGE = 3'd5;
  localparam step_t STEP_EMIT_STATUS = 3'd6;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_ROUND_COST,
    OP_ROUND_PAID,
    OP_SETUP,
    OP_SUBTRACT,
    OP_EMIT_CHANGE,
    OP_EMIT_STATUS,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_ITEM_VALID,
    COND_PAID_GT,
    COND_REST_GE,
    COND_REST_NONZERO
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump_to;
    step_t next_to;
  } ctrl_word_t;

  typedef struct packed {
    logic item_valid;
    logic paid_gt;
    logic rest_ge;
    logic rest_nonzero;
    logic cnt_nonzero;
    logic out_free;
  } seq_status_t;

  typedef struct packed {
    op_t  op;
    logic go;
  } seq_ctrl_t;

  // Denominations in cents, largest first.
  function automatic logic [DENOM_W-1:0] denom_value(logic [IDX_W-1:0] idx);
    logic [DENOM_W-1:0] v;
    case (idx)
      4'd0:    v = 11'd2000;
      4'd1:    v = 11'd1000;
      4'd2:    v = 11'd500;
      4'd3:    v = 11'd200;
      4'd4:    v = 11'd100;
      4'd5:    v = 11'd50;
      4'd6:    v = 11'd20;
      4'd7:    v = 11'd10;
      4'd8:    v = 11'd5;
      default: v = 11'd0;
    endcase
    return v;
  endfunction

  // The control program: a jump is taken when the condition holds.
  function automatic ctrl_word_t ucode(step_t pc);
    ctrl_word_t w;
    case (pc)
      STEP_IDLE:        w = '{OP_LOAD,        COND_ITEM_VALID,   STEP_ROUND_COST,
                              STEP_IDLE};
      STEP_ROUND_COST:  w = '{OP_ROUND_COST,  COND_ALWAYS,       STEP_ROUND_PAID,
                              STEP_ROUND_PAID};
      STEP_ROUND_PAID:  w = '{OP_ROUND_PAID,  COND_ALWAYS,       STEP_SETUP,
                              STEP_SETUP};
      STEP_SETUP:       w = '{OP_SETUP,       COND_PAID_GT,      STEP_SUBTRACT,
                              STEP_EMIT_STATUS};
      STEP_SUBTRACT:    w = '{OP_SUBTRACT,    COND_REST_GE,      STEP_SUBTRACT,
                              STEP_EMIT_CHANGE};
      STEP_EMIT_CHANGE: w = '{OP_EMIT_CHANGE, COND_REST_NONZERO, STEP_SUBTRACT,
                              STEP_IDLE};
      STEP_EMIT_STATUS: w = '{OP_EMIT_STATUS, COND_ALWAYS,       STEP_IDLE,
                              STEP_IDLE};
      default:          w = '{OP_NOP,         COND_ALWAYS,       STEP_IDLE,
                              STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

[src/rounded_greedy_change_maker_top.sv]
// Top level of the rounded greedy change maker: datapath, output register, sequencer.
//
// The input channel (item_valid, item_ready) takes one transaction holding a
// price and a payment in cents. Both are rounded to the nearest multiple of
// five cents, and the result channel (result_valid, result_ready) then gives
// either one status transaction (not enough money, or exact amount) or one
// change transaction per denomination with a nonzero count, largest first,
// with last set on the final one.
// The block works on one item at a time. A short microprogram steps a single
// rounding unit and a single compare and subtract unit: two rounding steps,
// one setup step, then either one status step or, for each denomination up
// to the last one paid out, one step per coin plus two. item_ready is high
// only while the sequencer waits at its idle step, which it reaches as soon
// as the last result sits in the output register, so the next item can be
// taken while that result still waits for the receiver. A stalled receiver
// holds the sequencer at its emitting step; nothing is dropped. Synchronous
// reset returns the sequencer to idle and empties the output register; the
// datapath registers are not reset and there is no clearing pass.
`include "rounded_greedy_change_maker_top_macros.svh"

module rounded_greedy_change_maker_top #(
  parameter int AMOUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  logic [rgcm_pkg::FIELD_BITS-1:0]    cost_cents,
  input  logic [rgcm_pkg::FIELD_BITS-1:0]    paid_cents,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [rgcm_pkg::KIND_W-1:0]        result_kind,
  output logic [rgcm_pkg::IDX_W-1:0]         denom_index,
  output logic [rgcm_pkg::COUNT_W-1:0]       coin_count,
  output logic                               last
);

  // Only the low bits of each amount count; rounding runs one bit wider.
  localparam int IN_BITS = (AMOUNT_BITS < rgcm_pkg::FIELD_BITS) ? AMOUNT_BITS
                                                                 : rgcm_pkg::FIELD_BITS;
  localparam int RW      = IN_BITS + 1;
  localparam int CMP_W   = (RW > rgcm_pkg::DENOM_W) ? RW : rgcm_pkg::DENOM_W;
  localparam int NIBBLES = (RW + 3) / 4;

  logic [RW-1:0]                cost_reg;
  logic [RW-1:0]                paid_reg;
  logic [RW-1:0]                rest;
  logic [rgcm_pkg::IDX_W-1:0]   idx;
  logic [rgcm_pkg::COUNT_W-1:0] cnt;

  rgcm_pkg::seq_status_t status;
  rgcm_pkg::seq_ctrl_t   ctrl;

  logic                  out_free;
  logic                  cnt_nonzero;
  logic                  rest_ge;
  logic [CMP_W-1:0]      rest_ext;
  logic [CMP_W-1:0]      denom_ext;
  logic [CMP_W-1:0]      rest_diff;
  logic                  status_shown;
  logic                  change_shown;

  // Rounding unit, shared by the price and payment steps.
  logic [RW-1:0]         round_in;
  logic [4*NIBBLES-1:0]  round_pad;
  logic [7:0]            nib_sum;
  logic [4:0]            fold1;
  logic [4:0]            fold2;
  logic [4:0]            residue;
  logic [RW-1:0]         rounded;

  assign round_in  = (ctrl.op == rgcm_pkg::OP_ROUND_PAID) ? paid_reg : cost_reg;
  assign round_pad = (4*NIBBLES)'(round_in);

  // Since 16 leaves remainder 1 modulo 5, summing hex digits keeps the residue.
  always_comb begin
    nib_sum = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      nib_sum = nib_sum + 8'(round_pad[4*i +: 4]);
    end
    fold1   = 5'(nib_sum[3:0]) + 5'(nib_sum[7:4]);
    fold2   = 5'(fold1[3:0]) + 5'(fold1[4]);
    residue = fold2;
    for (int j = 0; j < 3; j++) begin
      if (residue >= 5'd5) begin
        residue = residue - 5'd5;
      end
    end
  end

  always_comb begin
    case (residue)
      5'd1:    rounded = round_in - RW'(1);
      5'd2:    rounded = round_in - RW'(2);
      5'd3:    rounded = round_in + RW'(2);
      5'd4:    rounded = round_in + RW'(1);
      default: rounded = round_in;
    endcase
  end

  // Compare and subtract unit for the greedy split.
  assign rest_ext  = CMP_W'(rest);
  assign denom_ext = CMP_W'(rgcm_pkg::denom_value(idx));
  assign rest_ge   = rest_ext >= denom_ext;
  assign rest_diff = rest_ext - denom_ext;

  assign out_free    = !result_valid || result_ready;
  assign cnt_nonzero = cnt != '0;

  always_comb begin
    status.item_valid   = item_valid;
    status.paid_gt      = paid_reg > cost_reg;
    status.rest_ge      = rest_ge;
    status.rest_nonzero = rest != '0;
    status.cnt_nonzero  = cnt_nonzero;
    status.out_free     = out_free;
  end

  rgcm_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  assign item_ready = ctrl.op == rgcm_pkg::OP_LOAD;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      rgcm_pkg::OP_LOAD: begin
        if (item_valid) begin
          cost_reg <= RW'(cost_cents[IN_BITS-1:0]);
          paid_reg <= RW'(paid_cents[IN_BITS-1:0]);
        end
      end
      rgcm_pkg::OP_ROUND_COST: begin
        cost_reg <= rounded;
      end
      rgcm_pkg::OP_ROUND_PAID: begin
        paid_reg <= rounded;
      end
      rgcm_pkg::OP_SETUP: begin
        rest <= paid_reg - cost_reg;
        idx  <= '0;
        cnt  <= '0;
      end
      rgcm_pkg::OP_SUBTRACT: begin
        if (rest_ge) begin
          rest <= rest_diff[RW-1:0];
          if (cnt != rgcm_pkg::COUNT_MAX) begin
            cnt <= cnt + rgcm_pkg::COUNT_W'(1);
          end
        end
      end
      rgcm_pkg::OP_EMIT_CHANGE: begin
        if (ctrl.go) begin
          idx <= idx + rgcm_pkg::IDX_W'(1);
          cnt <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: filled by an emitting step, emptied by the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.go && ctrl.op == rgcm_pkg::OP_EMIT_CHANGE && cnt_nonzero) begin
      result_valid <= 1'b1;
    end else if (ctrl.go && ctrl.op == rgcm_pkg::OP_EMIT_STATUS) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go && ctrl.op == rgcm_pkg::OP_EMIT_CHANGE && cnt_nonzero) begin
      result_kind <= rgcm_pkg::KIND_CHANGE;
      denom_index <= idx;
      coin_count  <= cnt;
      last        <= rest == '0;
    end else if (ctrl.go && ctrl.op == rgcm_pkg::OP_EMIT_STATUS) begin
      result_kind <= (paid_reg < cost_reg) ? rgcm_pkg::KIND_NOT_ENOUGH
                                           : rgcm_pkg::KIND_EXACT;
      denom_index <= '0;
      coin_count  <= '0;
      last        <= 1'b1;
    end
  end

  assign status_shown = result_valid && result_kind != rgcm_pkg::KIND_CHANGE;
  assign change_shown = result_valid && result_kind == rgcm_pkg::KIND_CHANGE;

  `RGCM_ASSERT(a_status_is_last, clk, rst, status_shown |-> (last && coin_count == '0))
  `RGCM_ASSERT(a_status_index, clk, rst, status_shown |-> (denom_index == '0))
  `RGCM_ASSERT(a_change_nonzero, clk, rst, change_shown |-> (coin_count != '0))
  `RGCM_ASSERT(a_change_index, clk, rst, change_shown |-> (denom_index < rgcm_pkg::DENOM_COUNT))
  `RGCM_ASSERT_NEXT(a_one_item_at_once, clk, rst, item_valid && item_ready, !item_ready)

endmodule

[src/rgcm_sequencer.sv]
// Step counter and microcode lookup that steer the change maker datapath.
module rgcm_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  rgcm_pkg::seq_status_t status,
  output rgcm_pkg::seq_ctrl_t   ctrl
);

  rgcm_pkg::step_t      pc;
  rgcm_pkg::step_t      pc_next;
  rgcm_pkg::ctrl_word_t word;
  logic                 taken;
  logic                 stall;

  assign word = rgcm_pkg::ucode(pc);

  // Emitting steps that give a result wait while the output register still holds one.
  always_comb begin
    case (word.op)
      rgcm_pkg::OP_EMIT_CHANGE: stall = status.cnt_nonzero && !status.out_free;
      rgcm_pkg::OP_EMIT_STATUS: stall = !status.out_free;
      default:                  stall = 1'b0;
    endcase
  end

  always_comb begin
    case (word.cond)
      rgcm_pkg::COND_ALWAYS:       taken = 1'b1;
      rgcm_pkg::COND_ITEM_VALID:   taken = status.item_valid;
      rgcm_pkg::COND_PAID_GT:      taken = status.paid_gt;
      rgcm_pkg::COND_REST_GE:      taken = status.rest_ge;
      rgcm_pkg::COND_REST_NONZERO: taken = status.rest_nonzero;
      default:                     taken = 1'b1;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = word.jump_to;
    end else begin
      pc_next = word.next_to;
    end
  end

  always_comb begin
    ctrl.op = word.op;
    ctrl.go = !stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= rgcm_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[verif/rgcm_change_checker.sv]
// Checker for the rounded greedy change maker: predicts change results and compares them.
module rgcm_change_checker #(
  parameter int AMOUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic                            item_ready,
  input  logic [rgcm_pkg::FIELD_BITS-1:0] cost_cents,
  input  logic [rgcm_pkg::FIELD_BITS-1:0] paid_cents,
  input  logic                            result_valid,
  input  logic                            result_ready,
  input  logic [rgcm_pkg::KIND_W-1:0]     result_kind,
  input  logic [rgcm_pkg::IDX_W-1:0]      denom_index,
  input  logic [rgcm_pkg::COUNT_W-1:0]    coin_count,
  input  logic                            last,
  input  logic                            drain_done,
  output int                              pending_count,
  output int                              fail_count
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDE_BITS = rgcm_pkg::FIELD_BITS + 1;

  typedef struct packed {
    logic [rgcm_pkg::KIND_W-1:0]  kind;
    logic [rgcm_pkg::IDX_W-1:0]   idx;
    logic [rgcm_pkg::COUNT_W-1:0] count;
    logic                         last;
  } change_entry_t;

  localparam logic [rgcm_pkg::FIELD_BITS-1:0] AMOUNT_MASK =
    (AMOUNT_BITS >= rgcm_pkg::FIELD_BITS) ? '1
                                          : rgcm_pkg::FIELD_BITS'((1 << AMOUNT_BITS) - 1);

  // Coin values in cents, index 0 is the largest.
  localparam logic [rgcm_pkg::DENOM_COUNT-1:0][rgcm_pkg::DENOM_W-1:0] COIN_CENTS = {
    11'd5, 11'd10, 11'd20, 11'd50, 11'd100, 11'd200, 11'd500, 11'd1000, 11'd2000
  };

  change_entry_t expected_change_q[$];
  int            mismatch_count = 0;

  assign fail_count = mismatch_count + (drain_done ? pending_count : 0);

  // Rounds to the nearest multiple of five, one bit wider so it never wraps.
  function automatic logic [WIDE_BITS-1:0] round_to_nickel(
      logic [rgcm_pkg::FIELD_BITS-1:0] v);
    logic [WIDE_BITS-1:0] w;
    int unsigned          digit;
    w     = {1'b0, v};
    digit = w % 10;
    case (digit)
      1, 6:    w = w - WIDE_BITS'(1);
      2, 7:    w = w - WIDE_BITS'(2);
      3, 8:    w = w + WIDE_BITS'(2);
      4, 9:    w = w + WIDE_BITS'(1);
      default: w = w;
    endcase
    return w;
  endfunction

  // Works out the results of one item and queues them in order.
  function automatic void predict_change(logic [rgcm_pkg::FIELD_BITS-1:0] cost_raw,
                                         logic [rgcm_pkg::FIELD_BITS-1:0] paid_raw);
    logic [WIDE_BITS-1:0] cost_r;
    logic [WIDE_BITS-1:0] paid_r;
    int unsigned          rest;
    int unsigned          counts[rgcm_pkg::DENOM_COUNT];
    int                   final_idx;
    change_entry_t        entry;
    cost_r = round_to_nickel(cost_raw & AMOUNT_MASK);
    paid_r = round_to_nickel(paid_raw & AMOUNT_MASK);
    if (paid_r < cost_r) begin
      entry = '{rgcm_pkg::KIND_NOT_ENOUGH, '0, '0, 1'b1};
      expected_change_q.push_back(entry);
    end else if (paid_r == cost_r) begin
      entry = '{rgcm_pkg::KIND_EXACT, '0, '0, 1'b1};
      expected_change_q.push_back(entry);
    end else begin
      rest      = 32'(paid_r - cost_r);
      final_idx = 0;
      for (int i = 0; i < rgcm_pkg::DENOM_COUNT; i++) begin
        counts[i] = rest / COIN_CENTS[i];
        rest      = rest - counts[i] * COIN_CENTS[i];
        if (counts[i] != 0) final_idx = i;
      end
      for (int i = 0; i < rgcm_pkg::DENOM_COUNT; i++) begin
        if (counts[i] != 0) begin
          entry.kind  = rgcm_pkg::KIND_CHANGE;
          entry.idx   = i[rgcm_pkg::IDX_W-1:0];
          entry.count = (counts[i] > rgcm_pkg::COUNT_MAX) ? rgcm_pkg::COUNT_MAX
                                                          : counts[i][rgcm_pkg::COUNT_W-1:0];
          entry.last  = (i == final_idx);
          expected_change_q.push_back(entry);
        end
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    change_entry_t want;
    if (!rst) begin
      // Results are checked before the new item is predicted, so an unexpected
      // result in the same cycle as an accepted item is still caught.
      if (result_valid && result_ready) begin
        if (expected_change_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got kind %0d index %0d %s",
                   $time, result_kind, denom_index,
                   $sformatf("count %0d last %0d", coin_count, last));
          mismatch_count++;
        end else begin
          want = expected_change_q.pop_front();
          if ({result_kind, denom_index, coin_count, last} !== want) begin
            if (result_kind !== want.kind)
              $display("%0t: result_kind expected %0d, got %0d", $time, want.kind, result_kind);
            if (denom_index !== want.idx)
              $display("%0t: denom_index expected %0d, got %0d", $time, want.idx, denom_index);
            if (coin_count !== want.count)
              $display("%0t: coin_count expected %0d, got %0d", $time, want.count, coin_count);
            if (last !== want.last)
              $display("%0t: last expected %0d, got %0d", $time, want.last, last);
            mismatch_count++;
          end
        end
      end
      if (item_valid && item_ready) predict_change(cost_cents, paid_cents);
      pending_count <= expected_change_q.size();
    end
  end

  always @(posedge drain_done) begin
    if (pending_count != 0)
      $display("%0t: %0d expected results never arrived", $time, pending_count);
  end

endmodule

[verif/rounded_greedy_change_maker_top_tb.sv]
// Testbench top for the rounded greedy change maker: clock, reset, stimulus and verdict.
module rounded_greedy_change_maker_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Number of random items after the directed ones.
  localparam int RANDOM_ITEMS = 460;
  // Cycles without any transaction before the run is declared hung. The slowest
  // correct gap is one full item plus a sender gap and a receiver stall, so
  // this leaves a wide margin.
  localparam int HANG_LIMIT = 2000;
  // Settling time after the last expected result, longer than one item.
  localparam int DRAIN_CYCLES = 80;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            item_valid = 1'b0;
  logic                            item_ready;
  logic [rgcm_pkg::FIELD_BITS-1:0] cost_cents = '0;
  logic [rgcm_pkg::FIELD_BITS-1:0] paid_cents = '0;
  logic                            result_valid;
  logic                            result_ready = 1'b0;
  logic [rgcm_pkg::KIND_W-1:0]     result_kind;
  logic [rgcm_pkg::IDX_W-1:0]      denom_index;
  logic [rgcm_pkg::COUNT_W-1:0]    coin_count;
  logic                            last;
  logic                            drain_done = 1'b0;
  int                              pending_count;
  int                              fail_count;
  int                              hang_cycles = 0;
  int                              sender_calm = 0;
  int                              receiver_calm = 0;

  always #2 clk = ~clk;

  rounded_greedy_change_maker_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .cost_cents   (cost_cents),
    .paid_cents   (paid_cents),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_kind  (result_kind),
    .denom_index  (denom_index),
    .coin_count   (coin_count),
    .last         (last)
  );

  rgcm_change_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .cost_cents    (cost_cents),
    .paid_cents    (paid_cents),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result_kind   (result_kind),
    .denom_index   (denom_index),
    .coin_count    (coin_count),
    .last          (last),
    .drain_done    (drain_done),
    .pending_count (pending_count),
    .fail_count    (fail_count)
  );

  // Draws the idle cycles before the next transaction on one side. Now and
  // then a calm stretch starts in which the side never idles, so that
  // back-to-back traffic is exercised as well as random gaps.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Offers one price/payment transaction and returns once it is accepted. With
  // no gap, valid simply stays high and only the payload changes, so valid
  // never sees two assignments in one time step.
  task automatic send_item(input logic [rgcm_pkg::FIELD_BITS-1:0] cost,
                           input logic [rgcm_pkg::FIELD_BITS-1:0] paid);
    int gap;
    gap = draw_wait(sender_calm);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    cost_cents <= cost;
    paid_cents <= paid;
    do @(posedge clk); while (!item_ready);
  endtask

  // The receiver stalls a random number of cycles before each result, then
  // holds ready until a result transaction goes through.
  initial begin : receiver
    int stall;
    @(negedge rst);
    forever begin
      stall = draw_wait(receiver_calm);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  // A hung block shows up as a long run of cycles with no transaction at all.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [rgcm_pkg::FIELD_BITS-1:0] cost;
    logic [rgcm_pkg::FIELD_BITS-1:0] paid;
    int                              pick;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: range extremes, every status kind and each rounding digit.
    send_item(16'd0, 16'd0);          // zero price and zero payment is exact
    send_item(16'd0, 16'd65535);      // largest change, 32 of the largest note
    send_item(16'd65535, 16'd0);      // not enough at the extremes
    send_item(16'd65535, 16'd65535);  // equal at the top of the range
    send_item(16'd65533, 16'd65535);  // price rounds up onto the payment
    send_item(16'd65534, 16'd0);      // rounding up at the top must not wrap
    send_item(16'd0, 16'd3885);       // one of every denomination
    send_item(16'd0, 16'd5);          // smallest possible change
    send_item(16'd0, 16'd64000);      // only the largest denomination
    send_item(16'd0, 16'd11);         // last digit 1 rounds down
    send_item(16'd0, 16'd12);         // last digit 2 rounds down
    send_item(16'd0, 16'd13);         // last digit 3 rounds up
    send_item(16'd0, 16'd14);         // last digit 4 rounds up
    send_item(16'd0, 16'd16);         // last digit 6 rounds down
    send_item(16'd0, 16'd17);         // last digit 7 rounds down
    send_item(16'd0, 16'd18);         // last digit 8 rounds up
    send_item(16'd0, 16'd19);         // last digit 9 rounds up
    send_item(16'd0, 16'd4);          // a tiny payment rounds up to one coin
    send_item(16'd3, 16'd7);          // raw payment above price, rounded equal
    send_item(16'd8, 16'd7);          // rounding widens a shortfall
    send_item(16'd2, 16'd1);          // both round down to zero
    send_item(16'd1, 16'd2);          // raw payment above, both round to zero
    send_item(16'h5555, 16'hAAAA);    // alternating bit patterns
    send_item(16'hAAAA, 16'h5555);

    // Random part. Most items produce change so the subtract loop is busy; the
    // rest cover near-equal amounts, shortfalls and fully random pairs.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      cost = rgcm_pkg::FIELD_BITS'($urandom());
      if (pick < 45) begin
        paid = rgcm_pkg::FIELD_BITS'($urandom_range(cost, 16'hFFFF));
      end else if (pick < 60) begin
        cost = rgcm_pkg::FIELD_BITS'($urandom_range(0, 500));
        paid = rgcm_pkg::FIELD_BITS'(cost + $urandom_range(0, 600));
      end else if (pick < 72) begin
        cost = rgcm_pkg::FIELD_BITS'($urandom_range(4, 16'hFFFB));
        paid = rgcm_pkg::FIELD_BITS'(cost + $urandom_range(0, 8) - 4);
      end else if (pick < 88) begin
        paid = rgcm_pkg::FIELD_BITS'($urandom_range(0, cost));
      end else begin
        paid = rgcm_pkg::FIELD_BITS'($urandom());
      end
      send_item(cost, paid);
    end
    item_valid <= 1'b0;

    // Wait for the outstanding results, then give the block time to show any
    // result that should not be there. The first edge lets the count take in
    // the last item.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    drain_done <= 1'b1;
    @(posedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
